// ----- sv/dqrr_pkg.sv -----
// Package for the dual-queue round-robin scheduler.
// Holds item field widths, operation codes, FSM states and the queue control structs.
// Depends on nothing; used by dqrr_queue and dual_queue_rr_scheduler.
package dqrr_pkg;

  // Item field widths.
  localparam int ModeW  = 3;
  localparam int IdW    = 5;
  localparam int TicksW = 8;
  localparam int QuantW = 8;

  // Largest number of task ids that the id field can name.
  localparam int IdSpace = 2 ** IdW;

  // Stream payload widths, padded to whole bytes.
  localparam int InDataW  = 16;
  localparam int OutDataW = 8;

  // Configuration port.
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  // Configuration register indexes, taken from paddr[2].
  localparam logic RegQuantInteractive = 1'b0;
  localparam logic RegQuantCpuBound    = 1'b1;

  // Operation codes carried in the mode field.
  typedef enum logic [ModeW-1:0] {
    MODE_NEW   = 3'd0,
    MODE_ENQ   = 3'd1,
    MODE_PICK  = 3'd2,
    MODE_STEAL = 3'd3,
    MODE_TICK  = 3'd4
  } mode_e;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // Per-task record held in the task memory.
  typedef struct packed {
    logic              interactive;
    logic [TicksW-1:0] ticks;
  } task_rec_t;

  // Commands from the sequencer to one run queue.
  typedef struct packed {
    logic rd_en;     // read the head or tail entry (accept cycle)
    logic rd_tail;   // read the tail instead of the head
    logic push;      // append push_id at the tail
    logic pop;       // drop the entry that was read
    logic pop_tail;  // the dropped entry is the tail, else the head
  } q_cmd_t;

  // Status of one run queue.
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// ----- sv/dual_queue_rr_scheduler.sv -----
// Top level of the dual-queue round-robin scheduler.
// Depends on dqrr_pkg, dqrr_queue and dqrr_ram.
//
// Usage:
//   Commands arrive on the s_* stream: mode (new, enqueue, pick, steal, tick),
//   task_id and task_is_idle. Each accepted command yields exactly one result
//   transaction on the m_* stream: chosen_task, chosen_valid and resched_flag.
//   The quantum registers are written over the APB port (quantum_interactive at
//   address 0, quantum_cpu_bound at address 4) while no command is in flight.
// Sequencing:
//   A command is handled in its accept cycle, which reads the task memory and both
//   queue slot memories (one read port each), and then in the execute state, which
//   modifies and writes them back and loads the result register. No new command is
//   taken until the execute state of the last one completes.
// Reset:
//   Both queues are empty, all per-task records read as zero ticks and CPU-bound
//   through per-entry valid bits, and the quanta return to 2 and 4. No clearing
//   pass is needed, so the block is ready as soon as reset is released.
// Back pressure:
//   A result that is not taken holds in the output register. The next command is
//   still accepted; its write-back waits until the output register frees up.
module dual_queue_rr_scheduler #(
  parameter int MAX_TASKS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Command stream.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [2:0] mode, [7:3] task_id, [8] task_is_idle, [15:9] zero
  input  logic [dqrr_pkg::InDataW-1:0]   s_tdata,
  // Result stream.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [4:0] chosen_task, [5] chosen_valid, [6] resched_flag, [7] zero
  output logic [dqrr_pkg::OutDataW-1:0]  m_tdata,
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dqrr_pkg::ApbAddrW-1:0]  paddr,
  input  logic [dqrr_pkg::ApbDataW-1:0]  pwdata,
  output logic [dqrr_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);
  import dqrr_pkg::*;

  // Only ids below both MAX_TASKS and the id space are ever stored.
  localparam int TaskDepth = (MAX_TASKS < IdSpace) ? MAX_TASKS : IdSpace;
  localparam int IdxW      = $clog2(TaskDepth);
  localparam int RecW      = TicksW + 1;

  // Configuration registers.
  logic [QuantW-1:0] quant_int_q, quant_cpu_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quant_int_q <= QuantW'(2);
      quant_cpu_q <= QuantW'(4);
    end else if (cfg_wr) begin
      if (paddr[2] == RegQuantInteractive) begin
        quant_int_q <= pwdata[QuantW-1:0];
      end else begin
        quant_cpu_q <= pwdata[QuantW-1:0];
      end
    end
  end

  // Register read-back.
  assign prdata = (paddr[2] == RegQuantCpuBound) ? ApbDataW'(quant_cpu_q)
                                                : ApbDataW'(quant_int_q);

  // Sequencer and command registers.
  state_e             state_q, state_d;
  logic [ModeW-1:0]   mode_q;
  logic [IdW-1:0]     id_q;
  logic               idle_q;
  logic               accept;
  logic               done;
  logic [ModeW-1:0]   in_mode;
  logic [IdW-1:0]     in_id;
  logic               in_idle;

  assign in_mode = s_tdata[2:0];
  assign in_id   = s_tdata[7:3];
  assign in_idle = s_tdata[8];

  // Output register.
  logic               out_valid_q;
  logic [IdW-1:0]     out_task_q;
  logic               out_chosen_q;
  logic               out_resched_q;

  // Per-task state: record memory, its valid bits and the queued bits.
  logic [TaskDepth-1:0] rec_valid_q, rec_valid_d;
  logic [TaskDepth-1:0] queued_q, queued_d;
  logic [RecW-1:0]      rec_rdata;
  task_rec_t            rec_cur;
  task_rec_t            rec_wdata;
  logic                 rec_we;

  // Queues.
  q_cmd_t         iq_cmd, cq_cmd;
  q_stat_t        iq_stat, cq_stat;
  logic [IdW-1:0] iq_rd_id, cq_rd_id;

  // Results computed in the execute cycle.
  logic           res_valid;
  logic [IdW-1:0] res_task;
  logic           res_resched;
  logic           id_ok;
  logic [IdxW-1:0] idx;
  logic [TicksW-1:0] tick_next;

  assign s_tready = (state_q == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign done     = (state_q == ST_EXEC) && (!out_valid_q || m_tready);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Command capture; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= in_mode;
      id_q   <= in_id;
      idle_q <= in_idle;
    end
  end

  assign id_ok = (32'(id_q) < 32'(TaskDepth));
  assign idx   = id_q[IdxW-1:0];

  // A record that was never written reads as zero ticks, CPU-bound.
  assign rec_cur   = rec_valid_q[idx] ? task_rec_t'(rec_rdata) : '0;
  assign tick_next = (rec_cur.ticks != '0) ? rec_cur.ticks - TicksW'(1) : '0;

  // Execute: decide the result, queue commands and record write-back.
  always_comb begin
    iq_cmd         = '0;
    cq_cmd         = '0;
    iq_cmd.rd_en   = accept;
    cq_cmd.rd_en   = accept;
    iq_cmd.rd_tail = (mode_e'(in_mode) == MODE_STEAL);
    cq_cmd.rd_tail = (mode_e'(in_mode) == MODE_STEAL);
    res_valid      = 1'b0;
    res_task       = '0;
    res_resched    = 1'b0;
    rec_we         = 1'b0;
    rec_wdata      = rec_cur;
    rec_valid_d    = rec_valid_q;
    queued_d       = queued_q;

    if (done) begin
      unique case (mode_e'(mode_q))
        MODE_NEW: begin
          if (id_ok) begin
            rec_we                = 1'b1;
            rec_wdata.interactive = 1'b1;
            rec_wdata.ticks       = quant_int_q;
          end
        end
        MODE_ENQ: begin
          if (id_ok && !idle_q && !queued_q[idx]) begin
            if (rec_cur.interactive) begin
              if (!iq_stat.full) begin
                iq_cmd.push     = 1'b1;
                rec_we          = 1'b1;
                rec_wdata.ticks = quant_int_q;
                queued_d[idx]   = 1'b1;
              end
            end else begin
              if (!cq_stat.full) begin
                cq_cmd.push     = 1'b1;
                rec_we          = 1'b1;
                rec_wdata.ticks = quant_cpu_q;
                queued_d[idx]   = 1'b1;
              end
            end
          end
        end
        MODE_PICK: begin
          if (!iq_stat.empty) begin
            iq_cmd.pop = 1'b1;
            res_valid  = 1'b1;
            res_task   = iq_rd_id;
          end else if (!cq_stat.empty) begin
            cq_cmd.pop = 1'b1;
            res_valid  = 1'b1;
            res_task   = cq_rd_id;
          end
        end
        MODE_STEAL: begin
          if (!cq_stat.empty) begin
            cq_cmd.pop      = 1'b1;
            cq_cmd.pop_tail = 1'b1;
            res_valid       = 1'b1;
            res_task        = cq_rd_id;
          end else if (!iq_stat.empty) begin
            iq_cmd.pop      = 1'b1;
            iq_cmd.pop_tail = 1'b1;
            res_valid       = 1'b1;
            res_task        = iq_rd_id;
          end
        end
        MODE_TICK: begin
          if (id_ok && !idle_q) begin
            rec_we          = 1'b1;
            rec_wdata.ticks = tick_next;
            if (tick_next == '0) begin
              rec_wdata.interactive = 1'b0;
              res_resched           = 1'b1;
            end else if (tick_next == TicksW'(1)) begin
              rec_wdata.interactive = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase

      if (rec_we) begin
        rec_valid_d[idx] = 1'b1;
      end
      // The removed task leaves its queue.
      if (res_valid) begin
        queued_d[res_task[IdxW-1:0]] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_valid_q <= '0;
      queued_q    <= '0;
    end else begin
      rec_valid_q <= rec_valid_d;
      queued_q    <= queued_d;
    end
  end

  // Per-task record memory: read on accept, written back on completion.
  dqrr_ram #(
    .Width (RecW),
    .Depth (TaskDepth)
  ) u_task_mem (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (idx),
    .wdata_i (RecW'(rec_wdata)),
    .re_i    (accept),
    .raddr_i (in_id[IdxW-1:0]),
    .rdata_o (rec_rdata)
  );

  // Interactive run queue.
  dqrr_queue #(
    .Depth (TaskDepth)
  ) u_int_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (iq_cmd),
    .push_id_i (id_q),
    .rd_id_o   (iq_rd_id),
    .stat_o    (iq_stat)
  );

  // CPU-bound run queue.
  dqrr_queue #(
    .Depth (TaskDepth)
  ) u_cpu_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cq_cmd),
    .push_id_i (id_q),
    .rd_id_o   (cq_rd_id),
    .stat_o    (cq_stat)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (m_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_task_q    <= res_task;
      out_chosen_q  <= res_valid;
      out_resched_q <= res_resched;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {1'b0, out_resched_q, out_chosen_q, out_task_q};

  // A removed task must have been marked as queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   done && res_valid |-> queued_q[res_task[IdxW-1:0]])
    else $error("removed task was not marked queued");

  // Pushes and pops never go to a full or an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !(iq_cmd.push && iq_stat.full) && !(cq_cmd.push && cq_stat.full))
    else $error("push into a full run queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !(iq_cmd.pop && iq_stat.empty) && !(cq_cmd.pop && cq_stat.empty))
    else $error("pop from an empty run queue");

  // An accepted command blocks the next one for its execute cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   accept |=> !s_tready)
    else $error("command accepted during execute");

endmodule

// ----- sv/dqrr_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; no dependencies.
module dqrr_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/dqrr_queue.sv -----
// One run queue of task ids: a circular buffer in a dqrr_ram plus head and count.
// Depends on dqrr_pkg and dqrr_ram.
module dqrr_queue #(
  parameter int Depth = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dqrr_pkg::q_cmd_t        cmd_i,
  input  logic [dqrr_pkg::IdW-1:0] push_id_i,
  output logic [dqrr_pkg::IdW-1:0] rd_id_o,
  output dqrr_pkg::q_stat_t       stat_o
);
  import dqrr_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam int SumW = PtrW + 2;

  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [SumW-1:0] sum_ins, sum_tail;
  logic [SumW-1:0] ins_wrap, tail_wrap;
  logic [PtrW-1:0] ins_ptr, tail_ptr, rd_ptr;
  logic [SumW-1:0] head_inc;

  // Insert position is head + count and the tail is one before it, both modulo Depth.
  always_comb begin
    sum_ins   = SumW'(head_q) + SumW'(count_q);
    sum_tail  = sum_ins - SumW'(1);
    ins_wrap  = (sum_ins >= SumW'(Depth)) ? sum_ins - SumW'(Depth) : sum_ins;
    tail_wrap = (sum_tail >= SumW'(Depth)) ? sum_tail - SumW'(Depth) : sum_tail;
    ins_ptr   = ins_wrap[PtrW-1:0];
    tail_ptr  = tail_wrap[PtrW-1:0];
    rd_ptr    = cmd_i.rd_tail ? tail_ptr : head_q;
    head_inc  = SumW'(head_q) + SumW'(1);
  end

  // Pointer update for push and pop.
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CntW'(1);
      if (!cmd_i.pop_tail) begin
        head_d = (head_inc >= SumW'(Depth)) ? '0 : head_inc[PtrW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Slot storage.
  dqrr_ram #(
    .Width (IdW),
    .Depth (Depth)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (ins_ptr),
    .wdata_i (push_id_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_ptr),
    .rdata_o (rd_id_o)
  );

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(Depth));

  // The fill count never passes the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Depth))
    else $error("run queue count exceeds its depth");

endmodule

// ----- tb/tb_dual_queue_rr_scheduler.sv -----
// Self-checking testbench for the dual-queue round-robin scheduler.
// Drives command transactions and quantum writes, and checks each result transaction
// against an in-bench scheduler model. Depends on dqrr_pkg and dual_queue_rr_scheduler.
module tb_dual_queue_rr_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import dqrr_pkg::*;

  localparam int ClkHalf    = 5;
  localparam int ResetCycles = 9;
  localparam int NumTasks   = IdSpace;
  localparam int NumPhases  = 5;
  localparam int PhaseItems = 300;
  localparam int MaxReports = 10;
  localparam int IdlePct    = 29;
  localparam int SettleCycles = 8;

  // Mode codes that the block does not define.
  localparam logic [ModeW-1:0] ModeSpare5 = 3'd5;
  localparam logic [ModeW-1:0] ModeSpare6 = 3'd6;
  localparam logic [ModeW-1:0] ModeSpare7 = 3'd7;

  // Quantum values that the registers hold after reset.
  localparam logic [QuantW-1:0] ResetQuantInter = 8'd2;
  localparam logic [QuantW-1:0] ResetQuantCpu   = 8'd4;

  // One command: field order matches s_tdata from the highest bit down.
  typedef struct packed {
    logic             idle;
    logic [IdW-1:0]   id;
    logic [ModeW-1:0] mode;
  } sched_cmd_t;

  // One result: field order matches m_tdata from the highest bit down.
  typedef struct packed {
    logic           resched;
    logic           found;
    logic [IdW-1:0] chosen_id;
  } sched_res_t;

  // A row of the directed sequence; typed rows carry their own expected result.
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [IdW-1:0]   id;
    logic             idle;
    logic             typed;
    sched_res_t       res;
  } dir_row_t;

  localparam sched_res_t NoResult  = '0;
  localparam sched_res_t Resched   = '{1'b1, 1'b0, 5'd0};
  localparam sched_res_t Chose31   = '{1'b0, 1'b1, 5'd31};
  localparam sched_res_t Chose5    = '{1'b0, 1'b1, 5'd5};
  localparam sched_res_t Chose0    = '{1'b0, 1'b1, 5'd0};

  localparam int DirRows = 25;
  dir_row_t dir_rows [DirRows] = '{
    // Empty queues, undefined modes and idle-task commands.
    '{MODE_PICK,  5'd0,  1'b0, 1'b1, NoResult},
    '{MODE_STEAL, 5'd0,  1'b0, 1'b1, NoResult},
    '{ModeSpare5, 5'd31, 1'b1, 1'b1, NoResult},
    '{ModeSpare6, 5'd21, 1'b0, 1'b1, NoResult},
    '{ModeSpare7, 5'd10, 1'b1, 1'b1, NoResult},
    '{MODE_TICK,  5'd0,  1'b0, 1'b1, Resched},
    '{MODE_TICK,  5'd3,  1'b1, 1'b1, NoResult},
    '{MODE_ENQ,   5'd3,  1'b1, 1'b1, NoResult},
    // Fill both queues, including a repeated enqueue and a new on the idle task.
    '{MODE_NEW,   5'd31, 1'b0, 1'b1, NoResult},
    '{MODE_ENQ,   5'd31, 1'b0, 1'b1, NoResult},
    '{MODE_ENQ,   5'd31, 1'b0, 1'b1, NoResult},
    '{MODE_ENQ,   5'd0,  1'b0, 1'b1, NoResult},
    '{MODE_NEW,   5'd5,  1'b1, 1'b1, NoResult},
    '{MODE_ENQ,   5'd5,  1'b0, 1'b1, NoResult},
    // Pick takes the interactive head; steal prefers the CPU-bound tail.
    '{MODE_PICK,  5'd0,  1'b0, 1'b1, Chose31},
    '{MODE_STEAL, 5'd0,  1'b0, 1'b1, Chose0},
    '{MODE_STEAL, 5'd0,  1'b0, 1'b1, Chose5},
    // Ticks on a task that is no longer queued, down to and past zero.
    '{MODE_TICK,  5'd31, 1'b0, 1'b0, NoResult},
    '{MODE_TICK,  5'd31, 1'b0, 1'b0, NoResult},
    '{MODE_TICK,  5'd31, 1'b0, 1'b1, Resched},
    // New on a queued task keeps its queue entry.
    '{MODE_ENQ,   5'd0,  1'b0, 1'b0, NoResult},
    '{MODE_NEW,   5'd0,  1'b0, 1'b0, NoResult},
    '{MODE_ENQ,   5'd0,  1'b0, 1'b0, NoResult},
    '{MODE_PICK,  5'd0,  1'b0, 1'b0, NoResult},
    '{MODE_PICK,  5'd0,  1'b0, 1'b1, NoResult}
  };

  // Quantum settings per random phase; the fourth phase draws its own values.
  logic [QuantW-1:0] phase_qi [NumPhases] = '{8'd1, 8'd255, 8'd0, 8'd0, 8'd3};
  logic [QuantW-1:0] phase_qc [NumPhases] = '{8'd1, 8'd255, 8'd0, 8'd0, 8'd200};

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [InDataW-1:0]    s_tdata;   // [2:0] mode, [7:3] task_id, [8] task_is_idle
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OutDataW-1:0]   m_tdata;   // [4:0] chosen_task, [5] chosen_valid, [6] resched_flag
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ApbAddrW-1:0]   paddr;
  logic [ApbDataW-1:0]   pwdata;
  logic [ApbDataW-1:0]   prdata;
  logic                  pready;

  // Scheduler state as the bench expects it.
  logic [TicksW-1:0] task_ticks [NumTasks];
  logic              task_inter [NumTasks];
  logic              task_on_q  [NumTasks];
  logic [IdW-1:0]    inter_runq [$];
  logic [IdW-1:0]    cpu_runq   [$];
  logic [QuantW-1:0] quant_inter = ResetQuantInter;
  logic [QuantW-1:0] quant_cpu   = ResetQuantCpu;

  sched_res_t  pending_results [$];
  bit          gaps_on = 1'b1;
  int unsigned mismatch_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned fill_bursts = 0;

  dual_queue_rr_scheduler #(
    .MAX_TASKS(NumTasks)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #ClkHalf clk_i = ~clk_i;

  // Works out the result of one command and advances the expected state.
  function automatic sched_res_t predict_schedule(sched_cmd_t c);
    sched_res_t r;
    r = '0;
    case (c.mode)
      MODE_NEW: begin
        task_ticks[c.id] = quant_inter;
        task_inter[c.id] = 1'b1;
      end
      MODE_ENQ: begin
        if (!c.idle && !task_on_q[c.id]) begin
          if (task_inter[c.id]) begin
            if (inter_runq.size() < NumTasks) begin
              inter_runq.push_back(c.id);
              task_ticks[c.id] = quant_inter;
              task_on_q[c.id]  = 1'b1;
            end
          end else if (cpu_runq.size() < NumTasks) begin
            cpu_runq.push_back(c.id);
            task_ticks[c.id] = quant_cpu;
            task_on_q[c.id]  = 1'b1;
          end
        end
      end
      MODE_PICK: begin
        if (inter_runq.size() != 0) begin
          r.chosen_id = inter_runq.pop_front();
          r.found     = 1'b1;
        end else if (cpu_runq.size() != 0) begin
          r.chosen_id = cpu_runq.pop_front();
          r.found     = 1'b1;
        end
      end
      MODE_STEAL: begin
        if (cpu_runq.size() != 0) begin
          r.chosen_id = cpu_runq.pop_back();
          r.found     = 1'b1;
        end else if (inter_runq.size() != 0) begin
          r.chosen_id = inter_runq.pop_back();
          r.found     = 1'b1;
        end
      end
      MODE_TICK: begin
        if (!c.idle) begin
          if (task_ticks[c.id] != '0) task_ticks[c.id] = task_ticks[c.id] - TicksW'(1);
          if (task_ticks[c.id] == '0) begin
            task_inter[c.id] = 1'b0;
            r.resched        = 1'b1;
          end else if (task_ticks[c.id] == 8'd1) begin
            task_inter[c.id] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (r.found) task_on_q[r.chosen_id] = 1'b0;
    return r;
  endfunction

  function automatic void flag_mismatch(string what);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxReports) $display("MISMATCH: %s", what);
  endfunction

  // Offers one command, with random gaps, and records its expected result on accept.
  task automatic send_cmd(input sched_cmd_t c, input bit use_typed, input sched_res_t typed,
                          output sched_res_t r);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < IdlePct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= InDataW'(c);
    do @(posedge clk_i); while (!s_tready);
    r = predict_schedule(c);
    pending_results.push_back(use_typed ? typed : r);
    items_sent++;
  endtask

  task automatic send_op(input logic [ModeW-1:0] mode, input logic [IdW-1:0] id,
                         input logic idle, output sched_res_t r);
    sched_cmd_t c;
    c.mode = mode;
    c.id   = id;
    c.idle = idle;
    send_cmd(c, 1'b0, NoResult, r);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_access(input logic wr, input logic idx, input logic [ApbDataW-1:0] wdata,
                            output logic [ApbDataW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_quantum(input logic idx, input logic [QuantW-1:0] want);
    logic [ApbDataW-1:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (rd !== ApbDataW'(want))
      flag_mismatch($sformatf("quantum reg %0d read 0x%0h, expected 0x%0h", idx, rd, want));
  endtask

  // Writes a quantum register, mirrors it in the model and reads it back.
  task automatic set_quantum(input logic idx, input logic [QuantW-1:0] val);
    logic [ApbDataW-1:0] rd;
    apb_access(1'b1, idx, ApbDataW'(val), rd);
    if (idx == RegQuantInteractive) quant_inter = val;
    else quant_cpu = val;
    check_quantum(idx, val);
  endtask

  // Stops offering commands and waits until every result has come back.
  task automatic wait_idle();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Empties both queues, loads all tasks (one queue fills up when refresh makes all interactive), then drains again.
  task automatic fill_and_drain(input bit refresh);
    sched_res_t r;
    do send_op(MODE_PICK, '0, 1'b0, r); while (r.found);
    if (refresh)
      for (int i = 0; i < NumTasks; i++) send_op(MODE_NEW, IdW'(i), 1'b0, r);
    for (int i = 0; i < NumTasks; i++) send_op(MODE_ENQ, IdW'(i), 1'b0, r);
    send_op(MODE_ENQ, IdW'($urandom_range(NumTasks - 1)), 1'b0, r);
    do send_op($urandom_range(1) ? MODE_PICK : MODE_STEAL, '0, 1'b0, r); while (r.found);
    fill_bursts++;
  endtask

  // Typical lifetime of a time slice: create, enqueue, pick, run for a while, requeue.
  task automatic run_slice();
    sched_res_t r;
    logic [IdW-1:0] id;
    id = IdW'($urandom_range(NumTasks - 1));
    if ($urandom_range(1)) send_op(MODE_NEW, id, 1'b0, r);
    send_op(MODE_ENQ, id, 1'b0, r);
    send_op($urandom_range(3) == 0 ? MODE_STEAL : MODE_PICK, '0, 1'b0, r);
    if (r.found) begin
      id = r.chosen_id;
      repeat ($urandom_range(1, 6)) send_op(MODE_TICK, id, 1'b0, r);
      if ($urandom_range(3) != 0) send_op(MODE_ENQ, id, 1'b0, r);
    end
  endtask

  // Single command of any kind, with ids biased to a few tasks to revisit them.
  task automatic random_op();
    sched_res_t r;
    int unsigned roll;
    logic [ModeW-1:0] mode;
    logic [IdW-1:0] id;
    roll = $urandom_range(99);
    if (roll < 14) mode = MODE_NEW;
    else if (roll < 40) mode = MODE_ENQ;
    else if (roll < 58) mode = MODE_PICK;
    else if (roll < 68) mode = MODE_STEAL;
    else if (roll < 94) mode = MODE_TICK;
    else if (roll < 96) mode = ModeSpare5;
    else if (roll < 98) mode = ModeSpare6;
    else mode = ModeSpare7;
    id = $urandom_range(1) ? IdW'($urandom_range(7)) : IdW'($urandom_range(NumTasks - 1));
    send_op(mode, id, $urandom_range(99) < 8, r);
  endtask

  // Receiver side: random back pressure except during the no-gap phase.
  always @(negedge clk_i) begin
    m_tready <= !(gaps_on && $urandom_range(99) < IdlePct);
  end

  // Compare every result transaction with the oldest expected result.
  always @(posedge clk_i) begin : result_check
    sched_res_t want;
    sched_res_t got;
    if (rst_ni && m_tvalid && m_tready) begin
      got = m_tdata[$bits(sched_res_t)-1:0];
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result 0x%0h", m_tdata));
      end else begin
        want = pending_results.pop_front();
        if (got.chosen_id !== want.chosen_id || got.found !== want.found ||
            got.resched !== want.resched)
          flag_mismatch($sformatf(
            "result %0d: chosen %0d/%0d valid %0b/%0b resched %0b/%0b (exp/act)",
            results_seen, want.chosen_id, got.chosen_id, want.found, got.found,
            want.resched, got.resched));
      end
    end
  end

  // Stimulus: reset, directed table, then random phases under several quanta.
  initial begin : stimulus
    sched_res_t r;
    sched_cmd_t c;
    int unsigned target;
    logic [QuantW-1:0] qi;
    logic [QuantW-1:0] qc;
    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    for (int i = 0; i < NumTasks; i++) begin
      task_ticks[i] = '0;
      task_inter[i] = 1'b0;
      task_on_q[i]  = 1'b0;
    end
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    check_quantum(RegQuantInteractive, ResetQuantInter);
    check_quantum(RegQuantCpuBound, ResetQuantCpu);

    for (int i = 0; i < DirRows; i++) begin
      c.mode = dir_rows[i].mode;
      c.id   = dir_rows[i].id;
      c.idle = dir_rows[i].idle;
      send_cmd(c, dir_rows[i].typed, dir_rows[i].res, r);
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      qi = phase_qi[p];
      qc = phase_qc[p];
      if (p == 3) begin
        qi = QuantW'($urandom_range(1, 255));
        qc = QuantW'($urandom_range(1, 255));
      end
      set_quantum(RegQuantInteractive, qi);
      set_quantum(RegQuantCpuBound, qc);
      gaps_on = (p != 1);
      target = items_sent + PhaseItems;
      if (p == 0 || p == 3) fill_and_drain(p == 0);
      while (items_sent < target) begin
        if ($urandom_range(1)) run_slice();
        else random_op();
      end
    end

    wait_idle();
    $display("Covered %0d commands (%0d directed, %0d full-queue bursts), %0d results,",
             items_sent, DirRows, fill_bursts, results_seen);
    $display("over %0d quantum settings including zero and 255; %0d mismatches.",
             NumPhases + 1, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d results still pending.", pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
sv/dqrr_pkg.sv
sv/dqrr_ram.sv
sv/dqrr_queue.sv
sv/dual_queue_rr_scheduler.sv
tb/tb_dual_queue_rr_scheduler.sv
